[sv/las_pkg.sv]
// las_pkg: constants, codes and word types shared by the local alignment scorer
// depends on nothing; imported by every module of the block
`default_nettype none

package las_pkg;

    // sequence capacity and derived widths
    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int SYM_W   = 8;
    localparam int SCORE_W = 10;
    localparam int SCORE_MAX = (1 << SCORE_W) - 1;
    localparam int CFG_W   = 4;
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 2;

    // command codes of an input word
    localparam logic [CMD_W-1:0] CMD_APPEND_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN      = 2'd2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_MATCH_BONUS      = 2'd0;
    localparam logic [IDX_W-1:0] REG_MISMATCH_PENALTY = 2'd1;
    localparam logic [IDX_W-1:0] REG_GAP_PENALTY      = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] RST_MATCH_BONUS      = 4'd2;
    localparam logic [CFG_W-1:0] RST_MISMATCH_PENALTY = 4'd1;
    localparam logic [CFG_W-1:0] RST_GAP_PENALTY      = 4'd1;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SYM_W-1:0] symbol;
    } las_in_t;

    typedef struct packed {
        logic [SCORE_W-1:0] best_score;
        logic [LEN_W-1:0]   best_row;
        logic [LEN_W-1:0]   best_col;
        logic               overflow;
    } las_out_t;

    typedef struct packed {
        logic [CFG_W-1:0] match_bonus;
        logic [CFG_W-1:0] mismatch_penalty;
        logic [CFG_W-1:0] gap_penalty;
    } las_cfg_t;

    // row word travelling along the cell array
    typedef struct packed {
        logic               valid;
        logic [SYM_W-1:0]   sym;
        logic [LEN_W-1:0]   row;
        logic [SCORE_W-1:0] h;
    } las_bus_t;

    // best cell of one column
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [LEN_W-1:0]   row;
    } las_best_t;

    // controller to datapath
    typedef struct packed {
        logic             append_a;
        logic             append_b;
        logic             clear;
        logic             feed;
        logic             scan;
        logic [LEN_W-1:0] idx;
        logic             load_result;
        logic             clear_seq;
    } las_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [LEN_W-1:0] len_a;
        logic [LEN_W-1:0] len_b;
    } las_stat_t;

endpackage

`default_nettype wire

[sv/las_cell.sv]
// las_cell: one processing element of the systolic row, owns one column
// depends on las_pkg
`default_nettype none

module las_cell
    import las_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      clear,
    input  wire logic      shift,
    input  wire logic      b_we,
    input  wire logic [SYM_W-1:0] b_sym,
    input  wire las_cfg_t  cfg,
    input  wire las_bus_t  bus_i,
    output las_bus_t       bus_o,
    input  wire las_best_t best_i,
    output las_best_t      best_o
);

    localparam int CALC_W = SCORE_W + 2;
    localparam logic signed [CALC_W-1:0] CELL_CAP = CALC_W'(SCORE_MAX);

    logic [SYM_W-1:0]   b_sym_reg;
    logic [SCORE_W-1:0] h_reg;
    logic [SCORE_W-1:0] diag_reg;
    logic               v_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic [LEN_W-1:0]   row_reg;
    las_best_t          best_reg;

    logic signed [CALC_W-1:0] diag_s, up_s, left_s, max_s;
    logic signed [CALC_W-1:0] bonus_s, mis_s, gap_s;
    logic [SCORE_W-1:0]       cell_score;

    always_comb begin
        bonus_s = {{(CALC_W-CFG_W){1'b0}}, cfg.match_bonus};
        mis_s   = {{(CALC_W-CFG_W){1'b0}}, cfg.mismatch_penalty};
        gap_s   = {{(CALC_W-CFG_W){1'b0}}, cfg.gap_penalty};
        if (bus_i.sym == b_sym_reg) begin
            diag_s = $signed({2'b00, diag_reg}) + bonus_s;
        end else begin
            diag_s = $signed({2'b00, diag_reg}) - mis_s;
        end
        up_s   = $signed({2'b00, h_reg}) - gap_s;
        left_s = $signed({2'b00, bus_i.h}) - gap_s;
        max_s  = '0;
        if (diag_s > max_s) max_s = diag_s;
        if (up_s > max_s) max_s = up_s;
        if (left_s > max_s) max_s = left_s;
        cell_score = (max_s > CELL_CAP) ? SCORE_W'(SCORE_MAX) : max_s[SCORE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (b_we) begin
            b_sym_reg <= b_sym;
        end
    end

    always_ff @(posedge aclk) begin
        if (clear) begin
            h_reg    <= '0;
            diag_reg <= '0;
            v_reg    <= 1'b0;
            best_reg <= '0;
        end else begin
            v_reg <= bus_i.valid;
            if (bus_i.valid) begin
                h_reg    <= cell_score;
                diag_reg <= bus_i.h;
                sym_reg  <= bus_i.sym;
                row_reg  <= bus_i.row;
                if (cell_score > best_reg.score) begin
                    best_reg.score <= cell_score;
                    best_reg.row   <= bus_i.row;
                end
            end else if (shift) begin
                best_reg <= best_i;
            end
        end
    end

    assign bus_o.valid = v_reg;
    assign bus_o.sym   = sym_reg;
    assign bus_o.row   = row_reg;
    assign bus_o.h     = h_reg;
    assign best_o      = best_reg;

endmodule

`default_nettype wire

[sv/las_datapath.sv]
// las_datapath: configuration registers, sequence a memory, cell row, column reducer
// depends on las_pkg and las_cell
`default_nettype none

module las_datapath
    import las_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [SYM_W-1:0] s_symbol,
    input  wire logic             cfg_valid,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire las_cmd_t         cmd,
    output las_stat_t             stat,
    output las_out_t              m_data
);

    las_cfg_t         cfg_reg;
    logic [LEN_W-1:0] len_a_reg, len_b_reg;
    logic             dropped_reg;
    logic [SYM_W-1:0] mem_a [MAX_LEN];
    logic [SYM_W-1:0] rd_sym_reg;
    logic             feed_v_reg;
    logic [LEN_W-1:0] feed_row_reg;
    logic [SCORE_W-1:0] g_score_reg;
    logic [LEN_W-1:0] g_row_reg, g_col_reg;
    las_out_t         res_reg;

    las_bus_t  bus   [MAX_LEN+1];
    las_best_t bests [MAX_LEN+1];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.match_bonus      <= RST_MATCH_BONUS;
            cfg_reg.mismatch_penalty <= RST_MISMATCH_PENALTY;
            cfg_reg.gap_penalty      <= RST_GAP_PENALTY;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MATCH_BONUS:      cfg_reg.match_bonus      <= cfg_data;
                REG_MISMATCH_PENALTY: cfg_reg.mismatch_penalty <= cfg_data;
                REG_GAP_PENALTY:      cfg_reg.gap_penalty      <= cfg_data;
                default: ;
            endcase
        end
    end

    // lengths and dropped flag
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_seq) begin
            len_a_reg   <= '0;
            len_b_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            if (cmd.append_a) begin
                if (len_a_reg == LEN_W'(MAX_LEN)) dropped_reg <= 1'b1;
                else len_a_reg <= len_a_reg + 1'b1;
            end
            if (cmd.append_b) begin
                if (len_b_reg == LEN_W'(MAX_LEN)) dropped_reg <= 1'b1;
                else len_b_reg <= len_b_reg + 1'b1;
            end
        end
    end

    // sequence a memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (cmd.append_a && len_a_reg != LEN_W'(MAX_LEN)) begin
            mem_a[len_a_reg[ADDR_W-1:0]] <= s_symbol;
        end
        if (cmd.feed) begin
            rd_sym_reg <= mem_a[cmd.idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            feed_v_reg <= 1'b0;
        end else begin
            feed_v_reg <= cmd.feed;
        end
        feed_row_reg <= cmd.idx + 1'b1;
    end

    assign bus[0].valid = feed_v_reg;
    assign bus[0].sym   = rd_sym_reg;
    assign bus[0].row   = feed_row_reg;
    assign bus[0].h     = '0;
    assign bests[MAX_LEN] = '0;

    for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
        las_cell u_cell (
            .aclk   (aclk),
            .clear  (cmd.clear),
            .shift  (cmd.scan),
            .b_we   (cmd.append_b && len_b_reg == LEN_W'(j)),
            .b_sym  (s_symbol),
            .cfg    (cfg_reg),
            .bus_i  (bus[j]),
            .bus_o  (bus[j+1]),
            .best_i (bests[j+1]),
            .best_o (bests[j])
        );
    end

    // column bests arrive one per cycle at the head of the chain while the scan runs
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            g_score_reg <= '0;
            g_row_reg   <= '0;
            g_col_reg   <= '0;
        end else if (cmd.scan) begin
            if (bests[0].score > g_score_reg ||
                (bests[0].score == g_score_reg && bests[0].row < g_row_reg)) begin
                g_score_reg <= bests[0].score;
                g_row_reg   <= bests[0].row;
                g_col_reg   <= cmd.idx + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            res_reg.best_score <= g_score_reg;
            res_reg.best_row   <= g_row_reg;
            res_reg.best_col   <= g_col_reg;
            res_reg.overflow   <= dropped_reg;
        end
    end

    assign stat.len_a = len_a_reg;
    assign stat.len_b = len_b_reg;
    assign m_data     = res_reg;

endmodule

`default_nettype wire

[sv/las_ctrl.sv]
// las_ctrl: sequencer for appends and alignment runs, owns the result valid
// depends on las_pkg
`default_nettype none

module las_ctrl
    import las_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic [CMD_W-1:0] s_cmd,
    output logic                  s_ready,
    input  wire logic             m_ready,
    output logic                  m_valid,
    input  wire las_stat_t        stat,
    output las_cmd_t              cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CLEAR = 6'b000010,
        ST_FEED  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_SCAN  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.idx    = cnt_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_cmd)
                        CMD_APPEND_A: cmd.append_a = 1'b1;
                        CMD_APPEND_B: cmd.append_b = 1'b1;
                        CMD_RUN:      state_next   = ST_CLEAR;
                        default: ;
                    endcase
                end
            end
            ST_CLEAR: begin
                cmd.clear  = 1'b1;
                cnt_next   = '0;
                state_next = ST_FEED;
            end
            ST_FEED: begin
                if (cnt_reg == stat.len_a) begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end else begin
                    cmd.feed = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (cnt_reg == stat.len_b) begin
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SCAN: begin
                if (cnt_reg == stat.len_b) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.scan = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_result = 1'b1;
                    cmd.clear_seq   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load_result) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
        else m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a pending word");

    // an accepted run starts with the clearing step
    a_run_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_cmd == CMD_RUN) |=> state_reg == ST_CLEAR)
        else $error("run not started");

    // feed never passes the length of sequence a
    a_feed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FEED |-> cnt_reg <= stat.len_a)
        else $error("feed counter beyond sequence a");

    // scan never passes the length of sequence b
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan |-> cnt_reg < stat.len_b)
        else $error("scan beyond sequence b");

    // no input word is taken during a run
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input taken while busy");

endmodule

`default_nettype wire

[sv/local_alignment_scorer_core.sv]
// local_alignment_scorer_core: top level of the smith-waterman scorer
// depends on las_pkg, las_ctrl and las_datapath
`default_nettype none

// Smith-Waterman local alignment scorer with a linear gap cost. Each input
// word either appends a symbol to sequence a (up to 64 symbols, held in a
// small memory) or to sequence b (held one symbol per cell of a 64-cell
// systolic row), or starts a run. An append gives no result; an append to
// a full sequence is dropped and raises the overflow flag of the next
// result. A run clears the cell row, streams the a symbols through the row
// one per cycle, lets the last row ripple out and then shifts the per-column
// bests into a reducer one column a cycle. The run returns one word with the
// best score, its row and column (first maximum in row-major order, score 0
// at row 0, column 0 when nothing scores) and clears both sequences. Input
// words are refused during a run; appends are taken while a finished result
// still waits on the output register. Configuration writes (match bonus,
// mismatch penalty, gap penalty) are always taken and belong to idle periods
// only.
module local_alignment_scorer_core
    import las_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // input words
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire las_in_t          s_data,
    // result words
    output logic                  m_valid,
    input  wire logic             m_ready,
    output las_out_t              m_data,
    // register writes
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    las_cmd_t  cmd;
    las_stat_t stat;

    // register writes complete in the cycle they are offered
    assign cfg_ready = 1'b1;

    // sequencer: accepts words, steps a run through its phases
    las_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_data.cmd),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .stat    (stat),
        .cmd     (cmd)
    );

    // storage, cell row and best-cell reducer
    las_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_symbol  (s_data.symbol),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

[sim/las_scoreboard_pkg.sv]
// scoreboard for the local alignment scorer: mirrors the sequence stores and
// registers, scores each run word and checks result words in order
// depends on las_pkg
package las_scoreboard_pkg;

    import las_pkg::*;

    class alignment_scoreboard;

        logic [CFG_W-1:0] bonus;
        logic [CFG_W-1:0] mismatch_cost;
        logic [CFG_W-1:0] gap_cost;

        logic [SYM_W-1:0] seq_a[MAX_LEN];
        logic [SYM_W-1:0] seq_b[MAX_LEN];
        int unsigned      len_a;
        int unsigned      len_b;
        bit               dropped;

        las_out_t         expected_best[$];
        int unsigned      errors;

        function new();
            bonus         = RST_MATCH_BONUS;
            mismatch_cost = RST_MISMATCH_PENALTY;
            gap_cost      = RST_GAP_PENALTY;
            len_a         = 0;
            len_b         = 0;
            dropped       = 0;
            errors        = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_MATCH_BONUS:      bonus = val;
                REG_MISMATCH_PENALTY: mismatch_cost = val;
                REG_GAP_PENALTY:      gap_cost = val;
                default: ;
            endcase
        endfunction

        // fill the score matrix row by row, first strict maximum wins
        function las_out_t best_local_alignment();
            int       prev_row[MAX_LEN+1];
            int       cur_row[MAX_LEN+1];
            int       diag;
            int       up;
            int       left;
            int       score;
            int       best;
            int       best_i;
            int       best_j;
            las_out_t res;
            foreach (prev_row[k]) begin
                prev_row[k] = 0;
                cur_row[k]  = 0;
            end
            best   = 0;
            best_i = 0;
            best_j = 0;
            for (int i = 1; i <= len_a; i++) begin
                cur_row[0] = 0;
                for (int j = 1; j <= len_b; j++) begin
                    if (seq_a[i-1] == seq_b[j-1])
                        diag = prev_row[j-1] + int'(bonus);
                    else
                        diag = prev_row[j-1] - int'(mismatch_cost);
                    up    = prev_row[j] - int'(gap_cost);
                    left  = cur_row[j-1] - int'(gap_cost);
                    score = 0;
                    if (diag > score) score = diag;
                    if (up > score) score = up;
                    if (left > score) score = left;
                    if (score > SCORE_MAX) score = SCORE_MAX;
                    cur_row[j] = score;
                    if (score > best) begin
                        best   = score;
                        best_i = i;
                        best_j = j;
                    end
                end
                prev_row = cur_row;
            end
            res.best_score = best[SCORE_W-1:0];
            res.best_row   = best_i[LEN_W-1:0];
            res.best_col   = best_j[LEN_W-1:0];
            res.overflow   = dropped;
            return res;
        endfunction

        function void note_word(las_in_t w);
            las_out_t pred;
            case (w.cmd)
                CMD_APPEND_A: begin
                    if (len_a >= MAX_LEN) begin
                        dropped = 1;
                    end else begin
                        seq_a[len_a] = w.symbol;
                        len_a++;
                    end
                end
                CMD_APPEND_B: begin
                    if (len_b >= MAX_LEN) begin
                        dropped = 1;
                    end else begin
                        seq_b[len_b] = w.symbol;
                        len_b++;
                    end
                end
                CMD_RUN: begin
                    pred = best_local_alignment();
                    expected_best = {expected_best, pred};
                    len_a   = 0;
                    len_b   = 0;
                    dropped = 0;
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(las_out_t got);
            las_out_t want;
            if (expected_best.size() == 0) begin
                $error("result word with no run pending: score %0d row %0d col %0d",
                       got.best_score, got.best_row, got.best_col);
                errors++;
                return;
            end
            want = expected_best.pop_front();
            compare_field("best_score", want.best_score, got.best_score);
            compare_field("best_row", want.best_row, got.best_row);
            compare_field("best_col", want.best_col, got.best_col);
            compare_field("overflow", want.overflow, got.overflow);
        endfunction

    endclass

endpackage

[sim/tb_top.sv]
// tb_top: self-checking bench for local_alignment_scorer_core
// depends on las_pkg, las_scoreboard_pkg and the scorer rtl
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import las_pkg::*;
    import las_scoreboard_pkg::*;

    localparam int          CLK_HALF       = 5;
    localparam int          RESET_CYCLES   = 5;
    // long enough for a run still in flight to finish
    localparam int          SETTLE_CYCLES  = 256;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned ITEM_TARGET    = 1500;
    localparam int          PHASES         = 7;
    // the spare command code, which the block ignores
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    las_in_t          s_data;
    logic             m_valid;
    logic             m_ready;
    las_out_t         m_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    alignment_scoreboard sb;
    int unsigned         words_sent = 0;
    int unsigned         idle_cycles = 0;
    // when set the sender puts words out back to back
    bit                  sender_burst = 0;

    local_alignment_scorer_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 0;
    always #CLK_HALF aclk = ~aclk;

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // optional gap, then hold the word until it is taken
    task automatic send_word(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym);
        las_in_t     w;
        int unsigned gap;
        w.cmd    = cmd;
        w.symbol = sym;
        gap = sender_burst ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(w);
        if (cmd != CMD_NONE) words_sent++;
    endtask

    // sender goes quiet until every pending result is back and any run is over
    task automatic settle_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_best.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // one alignment job: two sequences, mostly over a small alphabet, interleaved,
    // then usually a run; b is often a noisy copy of a so real alignments form
    task automatic random_alignment();
        logic [SYM_W-1:0] a_syms[$];
        logic [SYM_W-1:0] b_syms[$];
        logic [SYM_W-1:0] base;
        int unsigned      la;
        int unsigned      lb;
        int unsigned      r;
        int unsigned      spread;
        bit               related;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            la = $urandom_range(0, 10);
            lb = $urandom_range(0, 10);
        end else if (r < 88) begin
            la = $urandom_range(11, 40);
            lb = $urandom_range(11, 40);
        end else if (r < 96) begin
            la = $urandom_range(41, MAX_LEN);
            lb = $urandom_range(41, MAX_LEN);
        end else begin
            // at least one sequence runs past capacity
            la = $urandom_range(40, MAX_LEN + 3);
            lb = $urandom_range(40, MAX_LEN + 3);
            if ($urandom_range(0, 1))
                la = MAX_LEN + $urandom_range(1, 3);
            else
                lb = MAX_LEN + $urandom_range(1, 3);
        end
        base    = SYM_W'($urandom_range(0, 255));
        spread  = ($urandom_range(0, 3) == 0) ? 255 : 3;
        related = $urandom_range(0, 99) < 45;
        for (int k = 0; k < la; k++)
            a_syms = {a_syms, SYM_W'(base ^ $urandom_range(0, spread))};
        for (int k = 0; k < lb; k++) begin
            if (related && k < la && $urandom_range(0, 9) < 8)
                b_syms = {b_syms, a_syms[k]};
            else
                b_syms = {b_syms, SYM_W'(base ^ $urandom_range(0, spread))};
        end
        sender_burst = ($urandom_range(0, 7) == 0);
        while (a_syms.size() != 0 || b_syms.size() != 0) begin
            if ($urandom_range(0, 99) < 3)
                send_word(CMD_NONE, SYM_W'($urandom_range(0, 255)));
            if (b_syms.size() == 0 || (a_syms.size() != 0 && $urandom_range(0, 1)))
                send_word(CMD_APPEND_A, a_syms.pop_front());
            else
                send_word(CMD_APPEND_B, b_syms.pop_front());
        end
        // now and then no run, so the symbols carry over into the next job
        if ($urandom_range(0, 99) < 95)
            send_word(CMD_RUN, SYM_W'($urandom_range(0, 255)));
    endtask

    // result side: random stalls, with the odd long stretch of ready held high
    initial begin
        int unsigned stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            if ($urandom_range(0, 19) == 0)
                repeat (300) @(negedge aclk);
            else
                repeat ($urandom_range(0, 6)) @(negedge aclk);
        end
    end

    // every result word taken is checked against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    // give up when no channel has moved a word for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        las_cfg_t    cfg;
        int unsigned target;
        sb        = new();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MATCH_BONUS;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed jobs under the reset scores
        // empty matrix reports zero at the origin
        send_word(CMD_RUN, 8'h00);
        // only a, then only b: no cells at all
        send_word(CMD_APPEND_A, 8'h00);
        send_word(CMD_RUN, 8'hFF);
        send_word(CMD_APPEND_B, 8'hFF);
        send_word(CMD_RUN, 8'h00);
        // single match
        send_word(CMD_APPEND_A, 8'hAA);
        send_word(CMD_APPEND_B, 8'hAA);
        send_word(CMD_RUN, 8'h00);
        // the spare command between appends changes nothing
        send_word(CMD_APPEND_A, 8'h01);
        send_word(CMD_NONE, 8'hFF);
        send_word(CMD_APPEND_B, 8'h01);
        send_word(CMD_RUN, 8'h00);
        // two equal maxima, the one earlier in row order wins
        send_word(CMD_APPEND_A, 8'h07);
        send_word(CMD_APPEND_A, 8'h07);
        send_word(CMD_APPEND_B, 8'h07);
        send_word(CMD_RUN, 8'h00);
        // mismatch then match off the diagonal start
        send_word(CMD_APPEND_A, 8'h55);
        send_word(CMD_APPEND_A, 8'hFF);
        send_word(CMD_APPEND_B, 8'h00);
        send_word(CMD_APPEND_B, 8'hFF);
        send_word(CMD_RUN, 8'h00);

        // random jobs, one score setting per phase, extremes first
        words_sent = 0;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: cfg = '{match_bonus: 4'd15, mismatch_penalty: 4'd15, gap_penalty: 4'd15};
                1: cfg = '{match_bonus: 4'd0, mismatch_penalty: 4'd0, gap_penalty: 4'd0};
                2: cfg = '{match_bonus: 4'd15, mismatch_penalty: 4'd0, gap_penalty: 4'd0};
                3: cfg = '{match_bonus: 4'd1, mismatch_penalty: 4'd15, gap_penalty: 4'd15};
                4: cfg = '{match_bonus: RST_MATCH_BONUS,
                           mismatch_penalty: RST_MISMATCH_PENALTY,
                           gap_penalty: RST_GAP_PENALTY};
                default: begin
                    cfg.match_bonus      = CFG_W'($urandom_range(0, 15));
                    cfg.mismatch_penalty = CFG_W'($urandom_range(0, 15));
                    cfg.gap_penalty      = CFG_W'($urandom_range(0, 15));
                end
            endcase
            // registers only change with the block idle
            settle_idle();
            write_reg(REG_MATCH_BONUS, cfg.match_bonus);
            write_reg(REG_MISMATCH_PENALTY, cfg.mismatch_penalty);
            write_reg(REG_GAP_PENALTY, cfg.gap_penalty);
            target = ITEM_TARGET * (phase + 1) / PHASES;
            while (words_sent < target)
                random_alignment();
        end

        settle_idle();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
